// ===== sv/i2cm_pkg.sv =====
// shared types and constants of the i2c master byte engine
package i2cm_pkg;

	localparam int unsigned HalfDelayW = 16;
	localparam int unsigned StretchW   = 24;
	localparam int unsigned CfgDataW   = 24;
	localparam int unsigned CfgIdxW    = 1;

	localparam logic [CfgIdxW-1:0] CFG_HALF_DELAY    = 1'd0;
	localparam logic [CfgIdxW-1:0] CFG_STRETCH_LIMIT = 1'd1;

	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_WRITE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	localparam logic [HalfDelayW-1:0] HALF_DELAY_RST    = 16'd250;
	localparam logic [StretchW-1:0]   STRETCH_LIMIT_RST = 24'd10000;
	localparam logic [7:0]            MSB_MASK          = 8'h80;

	localparam int unsigned QDepth = 2;
	localparam int unsigned QAw    = 1;
	localparam int unsigned QCw    = 2;

	typedef struct packed {
		logic       cmd_ok;
		logic [2:0] cmd;
		logic [7:0] data_byte;
		logic       nack_after_read;
		logic       scl_in;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       ready_res;
		logic       done_res;
		logic       acked;
		logic [7:0] read_data;
		logic       stop_ok;
		logic       arb_lost;
	} result_t;

	typedef struct packed {
		logic [QCw-1:0] level;
		logic           empty;
	} q_stat_t;

endpackage

// ===== sv/i2cm_if.sv =====
// transaction channels of the i2c master byte engine
interface i2cm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] data_byte;
	logic       nack_after_read;
	logic       scl_in;
	logic       sda_in;

	modport source(output valid, output cmd, output data_byte, output nack_after_read,
		output scl_in, output sda_in, input ready);
	modport sink(input valid, input cmd, input data_byte, input nack_after_read,
		input scl_in, input sda_in, output ready);
endinterface

interface i2cm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_release;
	logic       sda_release;
	logic       ready_res;
	logic       done_res;
	logic       acked;
	logic [7:0] read_data;
	logic       stop_ok;
	logic       arb_lost;

	modport source(output valid, output scl_release, output sda_release, output ready_res,
		output done_res, output acked, output read_data, output stop_ok, output arb_lost,
		input ready);
	modport sink(input valid, input scl_release, input sda_release, input ready_res,
		input done_res, input acked, input read_data, input stop_ok, input arb_lost,
		output ready);
endinterface

// ===== sv/i2cm_front.sv =====
// front end: accepts transactions, decodes the command and queues them
module i2cm_front (
	input  logic            clk,
	input  logic            arst_n,
	i2cm_in_if.sink         item_in,
	input  logic            pop,
	output i2cm_pkg::item_t head,
	output i2cm_pkg::q_stat_t q_stat
);

	i2cm_pkg::item_t                    q_mem_q [i2cm_pkg::QDepth];
	logic [i2cm_pkg::QAw-1:0]           wr_ptr_q;
	logic [i2cm_pkg::QAw-1:0]           rd_ptr_q;
	logic [i2cm_pkg::QCw-1:0]           level_q;
	logic                               push;
	logic                               full;
	i2cm_pkg::item_t                    item;

	assign full          = (level_q == i2cm_pkg::QCw'(i2cm_pkg::QDepth));
	assign item_in.ready = !full;
	assign push          = item_in.valid && !full;

	always_comb begin
		item.cmd_ok          = (item_in.cmd == i2cm_pkg::CMD_START) ||
			(item_in.cmd == i2cm_pkg::CMD_STOP) || (item_in.cmd == i2cm_pkg::CMD_WRITE) ||
			(item_in.cmd == i2cm_pkg::CMD_READ);
		item.cmd             = item_in.cmd;
		item.data_byte       = item_in.data_byte;
		item.nack_after_read = item_in.nack_after_read;
		item.scl_in          = item_in.scl_in;
		item.sda_in          = item_in.sda_in;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	assign head         = q_mem_q[rd_ptr_q];
	assign q_stat.level = level_q;
	assign q_stat.empty = (level_q == '0);

endmodule

// ===== sv/i2cm_back.sv =====
// back end: bus phase sequencer, config registers and result register
module i2cm_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [i2cm_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [i2cm_pkg::CfgDataW-1:0]       cfg_data,
	input  i2cm_pkg::item_t                     head,
	input  i2cm_pkg::q_stat_t                   q_stat,
	output logic                                pop,
	i2cm_out_if.source                          result_out
);

	localparam logic [4:0] PH_IDLE     = 5'd0;
	localparam logic [4:0] PH_RS_SDA   = 5'd1;
	localparam logic [4:0] PH_RS_SCL   = 5'd2;
	localparam logic [4:0] PH_RS_SETUP = 5'd3;
	localparam logic [4:0] PH_ST_CHECK = 5'd4;
	localparam logic [4:0] PH_ST_LOW   = 5'd5;
	localparam logic [4:0] PH_P_LOW    = 5'd6;
	localparam logic [4:0] PH_P_SCL    = 5'd7;
	localparam logic [4:0] PH_P_SETUP  = 5'd8;
	localparam logic [4:0] PH_P_HIGH   = 5'd9;
	localparam logic [4:0] PH_P_CHECK  = 5'd10;
	localparam logic [4:0] PH_P_TAIL   = 5'd11;
	localparam logic [4:0] PH_W_SDA    = 5'd12;
	localparam logic [4:0] PH_W_SCL    = 5'd13;
	localparam logic [4:0] PH_W_HOLD   = 5'd14;
	localparam logic [4:0] PH_R_SDA    = 5'd15;
	localparam logic [4:0] PH_R_SCL    = 5'd16;
	localparam logic [4:0] PH_R_HOLD   = 5'd17;

	logic [i2cm_pkg::HalfDelayW-1:0] half_delay_q;
	logic [i2cm_pkg::StretchW-1:0]   stretch_limit_q;

	logic [4:0]                      phase_q, n_phase, ent_ph;
	logic                            bus_q, n_bus;
	logic [i2cm_pkg::HalfDelayW-1:0] wait_q, n_wait;
	logic [i2cm_pkg::StretchW-1:0]   stretch_q, n_stretch;
	logic [3:0]                      bit_q, n_bit;
	logic [7:0]                      shift_q, n_shift;
	logic [2:0]                      act_q, n_act;
	logic                            nack_q, n_nack;
	logic                            ack_q, n_ack;
	logic                            arb_q, n_arb;
	logic                            scl_q, n_scl;
	logic                            sda_q, n_sda;
	logic                            ent, done;

	i2cm_pkg::result_t               res, res_q;
	logic                            res_valid_q;

	assign pop = !q_stat.empty && (!res_valid_q || result_out.ready);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_delay_q    <= i2cm_pkg::HALF_DELAY_RST;
			stretch_limit_q <= i2cm_pkg::STRETCH_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				i2cm_pkg::CFG_HALF_DELAY: begin
					half_delay_q <= cfg_data[i2cm_pkg::HalfDelayW-1:0];
				end
				i2cm_pkg::CFG_STRETCH_LIMIT: begin
					stretch_limit_q <= cfg_data[i2cm_pkg::StretchW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// one bus tick per transaction
	always_comb begin
		n_phase   = phase_q;
		n_bus     = bus_q;
		n_wait    = wait_q;
		n_stretch = stretch_q;
		n_bit     = bit_q;
		n_shift   = shift_q;
		n_act     = act_q;
		n_nack    = nack_q;
		n_ack     = ack_q;
		n_arb     = arb_q;
		n_scl     = scl_q;
		n_sda     = sda_q;
		ent       = 1'b0;
		ent_ph    = PH_IDLE;
		done      = 1'b0;

		unique case (phase_q)
			PH_IDLE: begin
				if (head.cmd_ok) begin
					n_act = head.cmd;
					n_arb = 1'b0;
					n_ack = 1'b0;
					n_bit = '0;
					ent   = 1'b1;
					unique case (head.cmd)
						i2cm_pkg::CMD_START: begin
							ent_ph = bus_q ? PH_RS_SDA : PH_ST_CHECK;
						end
						i2cm_pkg::CMD_STOP: begin
							ent_ph = PH_P_LOW;
						end
						i2cm_pkg::CMD_WRITE: begin
							n_shift = head.data_byte;
							ent_ph  = PH_W_SDA;
						end
						default: begin
							n_shift = '0;
							n_nack  = head.nack_after_read;
							ent_ph  = PH_R_SDA;
						end
					endcase
				end
			end
			PH_RS_SCL, PH_P_SCL, PH_W_SCL, PH_R_SCL: begin
				if (head.scl_in || (stretch_q >= stretch_limit_q)) begin
					ent = 1'b1;
					unique case (phase_q)
						PH_RS_SCL: begin
							ent_ph = PH_RS_SETUP;
						end
						PH_P_SCL: begin
							ent_ph = PH_P_SETUP;
						end
						PH_W_SCL: begin
							if (sda_q && !head.sda_in) begin
								n_arb = 1'b1;
							end
							ent_ph = PH_W_HOLD;
						end
						default: begin
							if (act_q == i2cm_pkg::CMD_READ) begin
								n_shift = {shift_q[6:0], head.sda_in};
							end else begin
								n_ack = !head.sda_in;
							end
							ent_ph = PH_R_HOLD;
						end
					endcase
				end else begin
					n_stretch = stretch_q + 1'b1;
				end
			end
			PH_ST_CHECK, PH_P_CHECK: begin
				if (!head.sda_in) begin
					n_arb = 1'b1;
				end
				ent    = 1'b1;
				ent_ph = (phase_q == PH_ST_CHECK) ? PH_ST_LOW : PH_P_TAIL;
			end
			default: begin
				if (phase_q > PH_R_HOLD) begin
					n_phase = PH_IDLE;
				end else if (wait_q == '0) begin
					unique case (phase_q)
						PH_RS_SDA: begin
							ent    = 1'b1;
							ent_ph = PH_RS_SCL;
						end
						PH_RS_SETUP: begin
							ent    = 1'b1;
							ent_ph = PH_ST_CHECK;
						end
						PH_ST_LOW: begin
							n_scl   = 1'b0;
							n_phase = PH_IDLE;
							done    = 1'b1;
						end
						PH_P_LOW: begin
							ent    = 1'b1;
							ent_ph = PH_P_SCL;
						end
						PH_P_SETUP: begin
							ent    = 1'b1;
							ent_ph = PH_P_HIGH;
						end
						PH_P_HIGH: begin
							ent    = 1'b1;
							ent_ph = PH_P_CHECK;
						end
						PH_P_TAIL: begin
							n_ack   = bus_q;
							n_bus   = 1'b0;
							n_phase = PH_IDLE;
							done    = 1'b1;
						end
						PH_W_SDA: begin
							ent    = 1'b1;
							ent_ph = PH_W_SCL;
						end
						PH_W_HOLD: begin
							n_scl = 1'b0;
							if (act_q == i2cm_pkg::CMD_WRITE) begin
								n_bit  = bit_q + 1'b1;
								ent    = 1'b1;
								ent_ph = n_bit[3] ? PH_R_SDA : PH_W_SDA;
							end else begin
								n_phase = PH_IDLE;
								done    = 1'b1;
							end
						end
						PH_R_SDA: begin
							ent    = 1'b1;
							ent_ph = PH_R_SCL;
						end
						PH_R_HOLD: begin
							n_scl = 1'b0;
							if (act_q == i2cm_pkg::CMD_READ) begin
								n_bit  = bit_q + 1'b1;
								ent    = 1'b1;
								ent_ph = n_bit[3] ? PH_W_SDA : PH_R_SDA;
							end else begin
								n_phase = PH_IDLE;
								done    = 1'b1;
							end
						end
						default: begin
							n_phase = PH_IDLE;
						end
					endcase
				end else begin
					n_wait = wait_q - 1'b1;
				end
			end
		endcase

		// entry actions of the new phase
		if (ent) begin
			n_phase   = ent_ph;
			n_wait    = half_delay_q;
			n_stretch = '0;
			unique case (ent_ph)
				PH_RS_SDA, PH_R_SDA, PH_P_HIGH: begin
					n_sda = 1'b1;
				end
				PH_RS_SCL, PH_P_SCL, PH_W_SCL, PH_R_SCL: begin
					n_scl = 1'b1;
				end
				PH_ST_CHECK: begin
					n_bus = 1'b1;
					n_sda = 1'b1;
				end
				PH_ST_LOW, PH_P_LOW: begin
					n_sda = 1'b0;
				end
				PH_W_SDA: begin
					if (n_act == i2cm_pkg::CMD_WRITE) begin
						n_sda = ((n_shift & (i2cm_pkg::MSB_MASK >> n_bit[2:0])) != '0);
					end else begin
						n_sda = n_nack;
					end
				end
				default: begin
				end
			endcase
		end

		res.scl_release = n_scl;
		res.sda_release = n_sda;
		res.ready_res   = (n_phase == PH_IDLE);
		res.done_res    = done;
		res.acked       = (n_act == i2cm_pkg::CMD_WRITE) && n_ack;
		res.read_data   = (n_act == i2cm_pkg::CMD_READ) ? n_shift : 8'd0;
		res.stop_ok     = (n_act == i2cm_pkg::CMD_STOP) && n_ack;
		res.arb_lost    = n_arb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bus_q       <= 1'b0;
			wait_q      <= '0;
			stretch_q   <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			act_q       <= i2cm_pkg::CMD_NONE;
			nack_q      <= 1'b0;
			ack_q       <= 1'b0;
			arb_q       <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q   <= n_phase;
				bus_q     <= n_bus;
				wait_q    <= n_wait;
				stretch_q <= n_stretch;
				bit_q     <= n_bit;
				shift_q   <= n_shift;
				act_q     <= n_act;
				nack_q    <= n_nack;
				ack_q     <= n_ack;
				arb_q     <= n_arb;
				scl_q     <= n_scl;
				sda_q     <= n_sda;
			end
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
		end
	end

	assign result_out.valid       = res_valid_q;
	assign result_out.scl_release = res_q.scl_release;
	assign result_out.sda_release = res_q.sda_release;
	assign result_out.ready_res   = res_q.ready_res;
	assign result_out.done_res    = res_q.done_res;
	assign result_out.acked       = res_q.acked;
	assign result_out.read_data   = res_q.read_data;
	assign result_out.stop_ok     = res_q.stop_ok;
	assign result_out.arb_lost    = res_q.arb_lost;

endmodule

// ===== sv/i2c_master_byte_engine.sv =====
// top level of the i2c master byte engine
//
// channel      dir  fields
// item_in      in   cmd, data_byte, nack_after_read, scl_in, sda_in
// result_out   out  scl_release, sda_release, ready_res, done_res, acked,
//                   read_data, stop_ok, arb_lost
// cfg_*        in   cfg_we, cfg_index, cfg_data (half_delay, stretch_limit)
//
// one transaction per cycle sustained while result_out is not stalled; each one is one bus tick of the sequencer
// a transaction passes through the two-entry queue, then into the result register
// arst_n clears the queue, the sequencer (idle, lines released) and the config to defaults
// a stalled result_out fills the queue, then item_in.ready drops
module i2c_master_byte_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	i2cm_in_if.sink                       item_in,
	i2cm_out_if.source                    result_out,
	input  logic                          cfg_we,
	input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [i2cm_pkg::CfgDataW-1:0] cfg_data
);

	i2cm_pkg::item_t   head;
	i2cm_pkg::q_stat_t q_stat;
	logic              pop;

	i2cm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item_in(item_in),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.result_out(result_out)
	);

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && result_out.done_res) |-> result_out.ready_res)
		else $error("command finished but sequencer not idle");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_out.valid |-> !(result_out.acked && result_out.stop_ok))
		else $error("ack and stop result flagged together");

	a_q_level: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level <= i2cm_pkg::QCw'(i2cm_pkg::QDepth))
		else $error("queue level beyond depth");

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("sequencer took a transaction from an empty queue");
`endif

endmodule

// ===== verif/tb.sv =====
// self-checking testbench of the i2c master byte engine: pin-level ticks against a cycle predictor
module tb;

	typedef enum logic [4:0] {
		S_IDLE, S_RS_SDA, S_RS_SCL, S_RS_SETUP, S_ST_CHECK, S_ST_LOW,
		S_P_LOW, S_P_SCL, S_P_SETUP, S_P_HIGH, S_P_CHECK, S_P_TAIL,
		S_W_SDA, S_W_SCL, S_W_HOLD, S_R_SDA, S_R_SCL, S_R_HOLD
	} seq_phase_t;

	typedef struct packed {
		seq_phase_t                      ph;
		logic                            started;
		logic [i2cm_pkg::HalfDelayW-1:0] wait_cnt;
		logic [i2cm_pkg::StretchW-1:0]   str_cnt;
		logic [3:0]                      bit_idx;
		logic [7:0]                      shreg;
		logic [2:0]                      cur_cmd;
		logic                            nack_sel;
		logic                            ack;
		logic                            arb;
		logic                            scl_o;
		logic                            sda_o;
	} engine_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data;
		logic       nack;
		logic       scl;
		logic       sda;
	} bus_tick_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] data;
		logic       nack;
	} plan_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [i2cm_pkg::CfgIdxW-1:0] cfg_index;
	logic [i2cm_pkg::CfgDataW-1:0] cfg_data;

	i2cm_in_if  item_if();
	i2cm_out_if res_if();

	i2c_master_byte_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(item_if),
		.result_out(res_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [i2cm_pkg::HalfDelayW-1:0] cfg_half = i2cm_pkg::HALF_DELAY_RST;
	logic [i2cm_pkg::StretchW-1:0]   cfg_stretch = i2cm_pkg::STRETCH_LIMIT_RST;

	engine_t            line_model;
	engine_t            stim_model;
	bus_tick_t          pin_ticks[$];
	i2cm_pkg::result_t  pending_results[$];
	plan_t              cmd_plan[$];

	int n_accepted = 0;
	int n_cmds = 0;
	int n_errors = 0;
	int n_results = 0;
	int send_gap = 0;
	int recv_stall = 0;
	int stretch_left = 0;
	int long_pct = 2;
	logic hold_off = 1'b0;

	bus_tick_t         taken;
	bus_tick_t         next_tick;
	i2cm_pkg::result_t got;
	i2cm_pkg::result_t want;

	always #5 clk = ~clk;

	function automatic engine_t reset_engine();
		engine_t e;
		e = '0;
		e.ph = S_IDLE;
		e.scl_o = 1'b1;
		e.sda_o = 1'b1;
		return e;
	endfunction

	function automatic void enter_phase(inout engine_t e, input seq_phase_t p,
			input logic [i2cm_pkg::HalfDelayW-1:0] half);
		e.ph = p;
		e.wait_cnt = half;
		e.str_cnt = '0;
		case (p)
			S_RS_SDA, S_P_HIGH, S_R_SDA: e.sda_o = 1'b1;
			S_ST_CHECK: begin
				e.started = 1'b1;
				e.sda_o = 1'b1;
			end
			S_RS_SCL, S_P_SCL, S_W_SCL, S_R_SCL: e.scl_o = 1'b1;
			S_ST_LOW, S_P_LOW: e.sda_o = 1'b0;
			S_W_SDA: e.sda_o = (e.cur_cmd == i2cm_pkg::CMD_WRITE) ?
				e.shreg[3'd7 - e.bit_idx[2:0]] : e.nack_sel;
			default: ;
		endcase
	endfunction

	// last tick of a timed phase: move on, or finish the command
	function automatic logic finish_delay(inout engine_t e,
			input logic [i2cm_pkg::HalfDelayW-1:0] half);
		logic fin;
		fin = 1'b0;
		case (e.ph)
			S_RS_SDA:   enter_phase(e, S_RS_SCL, half);
			S_RS_SETUP: enter_phase(e, S_ST_CHECK, half);
			S_ST_LOW: begin
				e.scl_o = 1'b0;
				e.ph = S_IDLE;
				fin = 1'b1;
			end
			S_P_LOW:    enter_phase(e, S_P_SCL, half);
			S_P_SETUP:  enter_phase(e, S_P_HIGH, half);
			S_P_HIGH:   enter_phase(e, S_P_CHECK, half);
			S_P_TAIL: begin
				e.ack = e.started;
				e.started = 1'b0;
				e.ph = S_IDLE;
				fin = 1'b1;
			end
			S_W_SDA:    enter_phase(e, S_W_SCL, half);
			S_W_HOLD: begin
				e.scl_o = 1'b0;
				if (e.cur_cmd == i2cm_pkg::CMD_WRITE) begin
					e.bit_idx = e.bit_idx + 4'd1;
					enter_phase(e, (e.bit_idx < 4'd8) ? S_W_SDA : S_R_SDA, half);
				end else begin
					e.ph = S_IDLE;
					fin = 1'b1;
				end
			end
			S_R_SDA:    enter_phase(e, S_R_SCL, half);
			S_R_HOLD: begin
				e.scl_o = 1'b0;
				if (e.cur_cmd == i2cm_pkg::CMD_READ) begin
					e.bit_idx = e.bit_idx + 4'd1;
					enter_phase(e, (e.bit_idx < 4'd8) ? S_R_SDA : S_W_SDA, half);
				end else begin
					e.ph = S_IDLE;
					fin = 1'b1;
				end
			end
			default: e.ph = S_IDLE;
		endcase
		return fin;
	endfunction

	function automatic i2cm_pkg::result_t advance_engine(inout engine_t e, input bus_tick_t t,
			input logic [i2cm_pkg::HalfDelayW-1:0] half,
			input logic [i2cm_pkg::StretchW-1:0] limit);
		i2cm_pkg::result_t r;
		logic fin;
		fin = 1'b0;
		case (e.ph)
			S_IDLE: begin
				if (t.cmd >= i2cm_pkg::CMD_START && t.cmd <= i2cm_pkg::CMD_READ) begin
					e.cur_cmd = t.cmd;
					e.arb = 1'b0;
					e.ack = 1'b0;
					e.bit_idx = '0;
					case (t.cmd)
						i2cm_pkg::CMD_START:
							enter_phase(e, e.started ? S_RS_SDA : S_ST_CHECK, half);
						i2cm_pkg::CMD_STOP:  enter_phase(e, S_P_LOW, half);
						i2cm_pkg::CMD_WRITE: begin
							e.shreg = t.data;
							enter_phase(e, S_W_SDA, half);
						end
						default: begin
							e.shreg = '0;
							e.nack_sel = t.nack;
							enter_phase(e, S_R_SDA, half);
						end
					endcase
				end
			end
			S_RS_SCL, S_P_SCL, S_W_SCL, S_R_SCL: begin
				if (t.scl || e.str_cnt >= limit) begin
					case (e.ph)
						S_RS_SCL: enter_phase(e, S_RS_SETUP, half);
						S_P_SCL:  enter_phase(e, S_P_SETUP, half);
						S_W_SCL: begin
							if (e.sda_o && !t.sda) e.arb = 1'b1;
							enter_phase(e, S_W_HOLD, half);
						end
						default: begin
							if (e.cur_cmd == i2cm_pkg::CMD_READ) e.shreg = {e.shreg[6:0], t.sda};
							else e.ack = ~t.sda;
							enter_phase(e, S_R_HOLD, half);
						end
					endcase
				end else begin
					e.str_cnt = e.str_cnt + 1'b1;
				end
			end
			S_ST_CHECK, S_P_CHECK: begin
				if (!t.sda) e.arb = 1'b1;
				enter_phase(e, (e.ph == S_ST_CHECK) ? S_ST_LOW : S_P_TAIL, half);
			end
			default: begin
				if (e.wait_cnt == '0) fin = finish_delay(e, half);
				else e.wait_cnt = e.wait_cnt - 1'b1;
			end
		endcase
		r.scl_release = e.scl_o;
		r.sda_release = e.sda_o;
		r.ready_res = (e.ph == S_IDLE);
		r.done_res = fin;
		r.acked = (e.cur_cmd == i2cm_pkg::CMD_WRITE) ? e.ack : 1'b0;
		r.read_data = (e.cur_cmd == i2cm_pkg::CMD_READ) ? e.shreg : 8'd0;
		r.stop_ok = (e.cur_cmd == i2cm_pkg::CMD_STOP) ? e.ack : 1'b0;
		r.arb_lost = e.arb;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 0;
		if (r < 96) return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	task automatic queue_cmd(input logic [2:0] c, input logic [7:0] d = 8'd0,
			input logic n = 1'b0);
		plan_t p;
		p.cmd = c;
		p.data = d;
		p.nack = n;
		cmd_plan.push_back(p);
	endtask

	// one bus tick: command field from the plan when idle, pins from a loose bus model
	task automatic emit_tick();
		bus_tick_t t;
		plan_t p;
		i2cm_pkg::result_t unused;
		t.cmd = 3'($urandom_range(0, 7));
		t.data = 8'($urandom);
		t.nack = 1'($urandom);
		if (stim_model.ph == S_IDLE) begin
			if (cmd_plan.size() > 0 && $urandom_range(0, 3) != 0) begin
				p = cmd_plan.pop_front();
				t.cmd = p.cmd;
				if (p.cmd == i2cm_pkg::CMD_WRITE) t.data = p.data;
				if (p.cmd == i2cm_pkg::CMD_READ) t.nack = p.nack;
				if (p.cmd >= i2cm_pkg::CMD_START && p.cmd <= i2cm_pkg::CMD_READ) n_cmds++;
			end else if ($urandom_range(0, 3) == 0) begin
				t.cmd = i2cm_pkg::CMD_NONE;
			end else begin
				t.cmd = 3'($urandom_range(int'(i2cm_pkg::CMD_READ) + 1, 7));
			end
		end
		if (stim_model.scl_o) begin
			if (stretch_left == 0) begin
				if ($urandom_range(0, 99) < 8) stretch_left = $urandom_range(1, 4);
				else if ($urandom_range(0, 99) < long_pct) stretch_left = $urandom_range(5, 60);
			end
			if (stretch_left > 0) begin
				t.scl = 1'b0;
				stretch_left--;
			end else begin
				t.scl = 1'b1;
			end
		end else begin
			t.scl = ($urandom_range(0, 19) == 0);
		end
		if (stim_model.sda_o) t.sda = ($urandom_range(0, 99) >= 30);
		else t.sda = ($urandom_range(0, 19) == 0);
		pin_ticks.push_back(t);
		unused = advance_engine(stim_model, t, cfg_half, cfg_stretch);
	endtask

	task automatic emit_until_done();
		while (cmd_plan.size() > 0 || stim_model.ph != S_IDLE) emit_tick();
	endtask

	task automatic plan_transfer();
		int n;
		if ($urandom_range(0, 9) < 8) begin
			queue_cmd(i2cm_pkg::CMD_START);
			queue_cmd(i2cm_pkg::CMD_WRITE, 8'($urandom));
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 1)) queue_cmd(i2cm_pkg::CMD_WRITE, 8'($urandom));
				else queue_cmd(i2cm_pkg::CMD_READ, 8'd0, (i == n - 1) ? 1'b1 : 1'($urandom));
			end
			if ($urandom_range(0, 3) == 0) begin
				queue_cmd(i2cm_pkg::CMD_START);
				queue_cmd(i2cm_pkg::CMD_WRITE, 8'($urandom));
				queue_cmd(i2cm_pkg::CMD_READ, 8'd0, 1'b1);
			end
			if ($urandom_range(0, 9) != 0) queue_cmd(i2cm_pkg::CMD_STOP);
		end else begin
			queue_cmd(3'($urandom_range(1, 7)), 8'($urandom), 1'($urandom));
		end
	endtask

	task automatic random_phase(input int n);
		int target;
		target = n_cmds + n;
		while (n_cmds < target) begin
			if (cmd_plan.size() == 0) plan_transfer();
			emit_tick();
		end
		queue_cmd(i2cm_pkg::CMD_STOP);
		emit_until_done();
	endtask

	task automatic drain();
		wait (pin_ticks.size() == 0 && !item_if.valid && pending_results.size() == 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [i2cm_pkg::CfgIdxW-1:0] idx,
			input logic [i2cm_pkg::CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == i2cm_pkg::CFG_HALF_DELAY) cfg_half = val[i2cm_pkg::HalfDelayW-1:0];
		else cfg_stretch = val[i2cm_pkg::StretchW-1:0];
	endtask

	task automatic set_config(input int half, input int limit);
		drain();
		write_reg(i2cm_pkg::CFG_HALF_DELAY, i2cm_pkg::CfgDataW'(half));
		write_reg(i2cm_pkg::CFG_STRETCH_LIMIT, i2cm_pkg::CfgDataW'(limit));
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_if.valid <= 1'b0;
		end else begin
			if (item_if.valid && item_if.ready) begin
				taken.cmd = item_if.cmd;
				taken.data = item_if.data_byte;
				taken.nack = item_if.nack_after_read;
				taken.scl = item_if.scl_in;
				taken.sda = item_if.sda_in;
				pending_results.push_back(advance_engine(line_model, taken, cfg_half,
					cfg_stretch));
				n_accepted++;
			end
			if (!item_if.valid || item_if.ready) begin
				if (send_gap > 0 || pin_ticks.size() == 0) begin
					item_if.valid <= 1'b0;
					if (send_gap > 0) send_gap--;
				end else begin
					next_tick = pin_ticks.pop_front();
					item_if.valid <= 1'b1;
					item_if.cmd <= next_tick.cmd;
					item_if.data_byte <= next_tick.data;
					item_if.nack_after_read <= next_tick.nack;
					item_if.scl_in <= next_tick.scl;
					item_if.sda_in <= next_tick.sda;
					send_gap = pick_gap();
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				n_results++;
				got.scl_release = res_if.scl_release;
				got.sda_release = res_if.sda_release;
				got.ready_res = res_if.ready_res;
				got.done_res = res_if.done_res;
				got.acked = res_if.acked;
				got.read_data = res_if.read_data;
				got.stop_ok = res_if.stop_ok;
				got.arb_lost = res_if.arb_lost;
				if (pending_results.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("transaction %0d: result with nothing expected (%h)",
							n_results, got);
				end else begin
					want = pending_results.pop_front();
					if (got.scl_release !== want.scl_release ||
							got.sda_release !== want.sda_release ||
							got.ready_res !== want.ready_res ||
							got.done_res !== want.done_res ||
							got.acked !== want.acked ||
							got.read_data !== want.read_data ||
							got.stop_ok !== want.stop_ok ||
							got.arb_lost !== want.arb_lost) begin
						n_errors++;
						if (n_errors <= 10)
							$display({"transaction %0d exp/got: scl %b/%b sda %b/%b rdy %b/%b",
								" done %b/%b ack %b/%b data %h/%h stop %b/%b arb %b/%b"},
								n_results, want.scl_release, got.scl_release,
								want.sda_release, got.sda_release, want.ready_res,
								got.ready_res, want.done_res, got.done_res, want.acked,
								got.acked, want.read_data, got.read_data, want.stop_ok,
								got.stop_ok, want.arb_lost, got.arb_lost);
					end
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= !hold_off;
				recv_stall = pick_gap();
			end
		end
	end

	// long receiver hold-off so the input side backs up
	initial begin
		wait (n_accepted >= 650);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#40000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_if.valid = 1'b0;
		item_if.cmd = i2cm_pkg::CMD_NONE;
		item_if.data_byte = '0;
		item_if.nack_after_read = 1'b0;
		item_if.scl_in = 1'b1;
		item_if.sda_in = 1'b1;
		res_if.ready = 1'b0;
		line_model = reset_engine();
		stim_model = reset_engine();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults
		queue_cmd(i2cm_pkg::CMD_START);
		emit_until_done();

		// directed: stop without start, unknown codes, every command, byte extremes
		set_config(0, 3);
		queue_cmd(i2cm_pkg::CMD_STOP);
		for (int c = int'(i2cm_pkg::CMD_READ) + 1; c < 8; c++) queue_cmd(3'(c));
		queue_cmd(i2cm_pkg::CMD_NONE);
		queue_cmd(i2cm_pkg::CMD_START);
		queue_cmd(i2cm_pkg::CMD_WRITE, 8'hff);
		queue_cmd(i2cm_pkg::CMD_WRITE, 8'h00);
		queue_cmd(i2cm_pkg::CMD_READ, 8'd0, 1'b0);
		queue_cmd(i2cm_pkg::CMD_READ, 8'd0, 1'b1);
		queue_cmd(i2cm_pkg::CMD_START);
		queue_cmd(i2cm_pkg::CMD_WRITE, 8'ha5);
		queue_cmd(i2cm_pkg::CMD_READ, 8'd0, 1'b1);
		queue_cmd(i2cm_pkg::CMD_STOP);
		queue_cmd(i2cm_pkg::CMD_STOP);
		emit_until_done();

		set_config(0, 0);
		random_phase(12);
		set_config(1, 24'hffffff);
		random_phase(6);
		long_pct = 10;
		set_config(2, 5);
		random_phase(5);
		long_pct = 2;
		set_config(3, 2);
		random_phase(2);

		drain();
		repeat (10) @(posedge clk);
		if (n_errors == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/i2cm_pkg.sv
sv/i2cm_if.sv
sv/i2cm_front.sv
sv/i2cm_back.sv
sv/i2c_master_byte_engine.sv
verif/tb.sv
